// File: hw/rtl/glc_pkg.sv
// ----------------------------------------------------------------------------
// glc_pkg
// Shared constants for the gcd / lcm / coprime unit: default operand width
// and sequencer state codes.
// ----------------------------------------------------------------------------
package glc_pkg;

  localparam int GLC_DATA_WIDTH = 32;

  localparam int GLC_ST_W = 3;

  localparam logic [GLC_ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [GLC_ST_W-1:0] ST_GSEL = 3'd1;
  localparam logic [GLC_ST_W-1:0] ST_GDIV = 3'd2;
  localparam logic [GLC_ST_W-1:0] ST_QDIV = 3'd3;
  localparam logic [GLC_ST_W-1:0] ST_MUL  = 3'd4;
  localparam logic [GLC_ST_W-1:0] ST_DONE = 3'd5;

endpackage

// File: hw/rtl/gcd_lcm_coprime_unit_core.sv
// ----------------------------------------------------------------------------
// gcd_lcm_coprime_unit_core
// Euclidean gcd, lcm with overflow flag and coprime test of two unsigned
// operands, all on one shared add/subtract unit under a small sequencer.
//
//   channel  dir  ports                       beat contents (low bit up)
//   in_      in   in_tvalid/tready/tdata      first_value, second_value
//   out_     out  out_tvalid/tready/tdata     gcd_value, lcm_value,
//                                             is_coprime, lcm_overflow,
//                                             lcm_undefined
//
// Each beat runs the Euclid remainder steps, each one bit-serial division,
// then a division of the first operand by the gcd and a shift-add multiply;
// the restoring divider and shift-add multiplier share one adder. Both
// operands zero skips the divide and multiply. in_tready is high only in the
// idle state. A finished result waits in the output register, so a stalled
// out_ side holds the next result in the done state. Reset: rst_n,
// synchronous, active low.
// ----------------------------------------------------------------------------
module gcd_lcm_coprime_unit_core #(
  parameter int DATA_WIDTH = glc_pkg::GLC_DATA_WIDTH
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  // first_value, second_value
  input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]               in_tdata,
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  // gcd_value, lcm_value, is_coprime, lcm_overflow, lcm_undefined
  output logic [((2*DATA_WIDTH+3+7)/8)*8-1:0]             out_tdata
);

  import glc_pkg::*;

  localparam int DW    = DATA_WIDTH;
  localparam int OUT_W = ((2*DATA_WIDTH+3+7)/8)*8;
  localparam int CNT_W = $clog2(DATA_WIDTH);

  logic [GLC_ST_W-1:0] state_r, state_nxt;
  logic [DW-1:0]       x_r, x_nxt;
  logic [DW-1:0]       y_r, y_nxt;
  logic [DW-1:0]       a_r, a_nxt;
  logic [DW-1:0]       b_r, b_nxt;
  logic [DW-1:0]       dvs_r, dvs_nxt;
  logic [DW-1:0]       rem_r, rem_nxt;
  logic [DW-1:0]       quo_r, quo_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic                sel_r, sel_nxt;
  logic                undef_r, undef_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]    out_data_r, out_data_nxt;

  logic [DW+1:0]       add_a, add_b, add_res;
  logic                add_sub;
  logic                div_ge;
  logic [DW-1:0]       div_rem;
  logic [DW-1:0]       div_quo;
  logic                cnt_last;
  logic [DW-1:0]       gcd_or;

  // shared add / subtract unit
  always_comb begin
    add_a   = '0;
    add_b   = '0;
    add_sub = 1'b1;
    case (state_r)
      ST_GSEL: begin
        add_a = {2'b00, y_r};
        add_b = {2'b00, x_r};
      end
      ST_GDIV, ST_QDIV: begin
        add_a = {1'b0, rem_r, quo_r[DW-1]};
        add_b = {2'b00, dvs_r};
      end
      ST_MUL: begin
        add_a   = {2'b00, rem_r};
        add_b   = quo_r[0] ? {2'b00, b_r} : '0;
        add_sub = 1'b0;
      end
      default: begin
        add_sub = 1'b1;
      end
    endcase
    add_res = add_sub ? (add_a - add_b) : (add_a + add_b);
  end

  assign div_ge   = ~add_res[DW+1];
  assign div_rem  = div_ge ? add_res[DW-1:0] : {rem_r[DW-2:0], quo_r[DW-1]};
  assign div_quo  = {quo_r[DW-2:0], div_ge};
  assign cnt_last = (cnt_r == CNT_W'(DW-1));
  assign gcd_or   = x_r | y_r;

  always_comb begin
    state_nxt     = state_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    dvs_nxt       = dvs_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    sel_nxt       = sel_r;
    undef_nxt     = undef_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          a_nxt     = in_tdata[DW-1:0];
          b_nxt     = in_tdata[2*DW-1:DW];
          x_nxt     = in_tdata[DW-1:0];
          y_nxt     = in_tdata[2*DW-1:DW];
          undef_nxt = 1'b0;
          state_nxt = ST_GSEL;
        end
      end
      ST_GSEL: begin
        rem_nxt = '0;
        cnt_nxt = '0;
        if (x_r == '0 || y_r == '0) begin
          x_nxt = gcd_or;
          if (gcd_or == '0) begin
            undef_nxt = 1'b1;
            quo_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            quo_nxt   = a_r;
            dvs_nxt   = gcd_or;
            state_nxt = ST_QDIV;
          end
        end else if (add_res[DW+1]) begin
          // x above y: reduce x modulo y
          sel_nxt   = 1'b1;
          quo_nxt   = x_r;
          dvs_nxt   = y_r;
          state_nxt = ST_GDIV;
        end else begin
          sel_nxt   = 1'b0;
          quo_nxt   = y_r;
          dvs_nxt   = x_r;
          state_nxt = ST_GDIV;
        end
      end
      ST_GDIV: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          if (sel_r) begin
            x_nxt = div_rem;
          end else begin
            y_nxt = div_rem;
          end
          state_nxt = ST_GSEL;
        end
      end
      ST_QDIV: begin
        rem_nxt = div_rem;
        quo_nxt = div_quo;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          // clear the high half ahead of the multiply
          rem_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        rem_nxt = add_res[DW:1];
        quo_nxt = {add_res[0], quo_r[DW-1:1]};
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_W'({undef_r, (rem_r != '0), (x_r == DW'(1)), quo_r, x_r});
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      sel_r       <= 1'b0;
      undef_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      sel_r       <= sel_nxt;
      undef_r     <= undef_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r        <= x_nxt;
    y_r        <= y_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    dvs_r      <= dvs_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a beat is still in work");

  a_undef_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r[2*DW+2] |->
      out_data_r[2*DW-1:0] == '0 && !out_data_r[2*DW+1] && !out_data_r[2*DW])
    else $error("undefined result with nonzero fields");

  a_gcd_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r[2*DW+2] |-> out_data_r[DW-1:0] != '0)
    else $error("zero gcd without undefined flag");

  a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_GDIV || state_r == ST_QDIV |-> dvs_r != '0)
    else $error("division by zero in sequencer");
`endif

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks gcd_lcm_coprime_unit_core on its two stream channels. Each accepted
// operand beat is run through a behavioural gcd/lcm calculation and the
// expected result is queued. Every result beat is compared field by field
// with the oldest queued result. Stimulus starts with edge operands and
// worst-case Euclid pairs, then moves to random pairs under four idling
// patterns on the operand and result sides.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import glc_pkg::*;

  localparam int W              = GLC_DATA_WIDTH;
  localparam int IN_W           = ((2*W+7)/8)*8;
  localparam int OUT_W          = ((2*W+3+7)/8)*8;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 200;
  localparam int PHASE_ITEMS    = 200;

  typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic         undefined;
    logic         overflow;
    logic         coprime;
    logic [W-1:0] lcm;
    logic [W-1:0] gcd;
  } gcd_lcm_result_t;

  logic             clk        = 1'b0;
  logic             rst_n      = 1'b0;
  logic             in_tvalid  = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata   = '0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  gcd_lcm_result_t pending_results[$];
  int              mismatch_count = 0;
  int              quiet_cycles   = 0;
  int              send_idle_pct  = 0;
  int              recv_stall_pct = 0;

  gcd_lcm_coprime_unit_core #(.DATA_WIDTH(W)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #6 clk = ~clk;

  function automatic gcd_lcm_result_t gcd_lcm_of(logic [W-1:0] a, logic [W-1:0] b);
    logic [W-1:0]   x;
    logic [W-1:0]   y;
    logic [W-1:0]   g;
    logic [2*W-1:0] product;
    gcd_lcm_result_t r;
    x = a;
    y = b;
    while (x != '0 && y != '0) begin
      if (x > y) x = x % y;
      else       y = y % x;
    end
    g = x + y;
    r = '0;
    r.gcd = g;
    r.coprime = (g == W'(1));
    if (g == '0) begin
      r.undefined = 1'b1;
    end else begin
      product = (2*W)'(a / g) * (2*W)'(b);
      r.lcm = product[W-1:0];
      r.overflow = (product[2*W-1:W] != '0);
    end
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    mismatch_count++;
  endtask

  task automatic compare_field(string name, logic [W-1:0] got, logic [W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
  endtask

  // results leave before operands enter, so pop first
  always @(posedge clk) begin
    gcd_lcm_result_t got;
    gcd_lcm_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[2*W+2:0];
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result beat 0x%0h with none pending", out_tdata));
        end else begin
          want = pending_results.pop_front();
          compare_field("gcd_value", got.gcd, want.gcd);
          compare_field("lcm_value", got.lcm, want.lcm);
          compare_field("is_coprime", W'(got.coprime), W'(want.coprime));
          compare_field("lcm_overflow", W'(got.overflow), W'(want.overflow));
          compare_field("lcm_undefined", W'(got.undefined), W'(want.undefined));
        end
      end
      if (in_tvalid && in_tready)
        pending_results.push_back(gcd_lcm_of(in_tdata[W-1:0], in_tdata[2*W-1:W]));
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  always @(negedge clk)
    out_tready = ($urandom_range(99) >= recv_stall_pct);

  task automatic set_idling(idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 74 : (mode == IDLE_BOTH) ? 8 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 74 : (mode == IDLE_BOTH) ? 8 : 0;
  endtask

  task automatic send_operands(logic [W-1:0] a, logic [W-1:0] b);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = '0;
    in_tdata[W-1:0]   = a;
    in_tdata[2*W-1:W] = b;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic release_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic wait_for_results();
    release_input();
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_edge_operands();
    logic [W-1:0] all_ones;
    logic [W-1:0] top_bit;
    all_ones = '1;
    top_bit  = W'(1) << (W-1);
    send_operands('0, '0);
    send_operands('0, W'(5));
    send_operands(W'(7), '0);
    send_operands('0, all_ones);
    send_operands(all_ones, '0);
    send_operands(W'(1), W'(1));
    send_operands(all_ones, all_ones);
    send_operands(all_ones, all_ones - W'(1));
    send_operands(W'(1), all_ones);
    send_operands(W'(12), W'(18));
    send_operands(W'(18), W'(12));
    send_operands(W'(65535), W'(65537));
    send_operands(W'(65536), W'(65537));
    send_operands(W'(65536), W'(65536));
    send_operands(top_bit, top_bit);
    send_operands(top_bit, W'(2));
    send_operands(W'(3), top_bit);
    send_operands({(W/2){2'b10}}, {(W/2){2'b01}});
  endtask

  // consecutive Fibonacci numbers take the most remainder steps
  task automatic test_euclid_worst_case();
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned nxt;
    lo = 1;
    hi = 1;
    while (lo + hi <= longint'({W{1'b1}})) begin
      nxt = lo + hi;
      lo  = hi;
      hi  = nxt;
    end
    send_operands(W'(hi), W'(lo));
    send_operands(W'(lo), W'(hi));
    send_operands(W'(hi - lo), W'(lo));
  endtask

  task automatic test_random_pairs(idle_mode_t mode, int count);
    logic [W-1:0]    a;
    logic [W-1:0]    b;
    longint unsigned g;
    set_idling(mode);
    repeat (count) begin
      case ($urandom_range(4))
        0: begin
          a = W'($urandom);
          b = W'($urandom);
        end
        1: begin
          g = $urandom_range(1, 4095);
          a = W'(g * $urandom_range(0, 1 << 20));
          b = W'(g * $urandom_range(0, 1 << 20));
        end
        2: begin
          a = W'($urandom_range(0, 300));
          b = W'($urandom_range(0, 300));
        end
        3: begin
          a = W'(1) << $urandom_range(0, W-1);
          b = W'($urandom) << $urandom_range(0, 16);
        end
        default: begin
          a = W'($urandom);
          b = $urandom_range(1) ? '0 : a;
          if ($urandom_range(1)) {a, b} = {b, a};
        end
      endcase
      send_operands(a, b);
    end
    wait_for_results();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    set_idling(IDLE_NONE);
    test_edge_operands();
    test_euclid_worst_case();
    wait_for_results();

    test_random_pairs(IDLE_NONE, PHASE_ITEMS);
    test_random_pairs(IDLE_SENDER, PHASE_ITEMS);
    test_random_pairs(IDLE_RECEIVER, PHASE_ITEMS);
    test_random_pairs(IDLE_BOTH, PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/glc_pkg.sv
hw/rtl/gcd_lcm_coprime_unit_core.sv
dv/testbench.sv
